@@ rtl/core/iptp_pkg.sv @@
// Shared types and constants of the IPv6 text address parser.
package iptp_pkg;

	// Character codes
	localparam logic [7:0] CharColon  = 8'h3A;
	localparam logic [7:0] CharDigit0 = 8'h30;
	localparam logic [7:0] CharDigit9 = 8'h39;
	localparam logic [7:0] CharLowerA = 8'h61;
	localparam logic [7:0] CharLowerF = 8'h66;
	localparam logic [7:0] CharUpperA = 8'h41;
	localparam logic [7:0] CharUpperF = 8'h46;
	localparam logic [7:0] HexTen     = 8'd10;

	// Address geometry
	localparam int unsigned GroupCount = 8;
	localparam int unsigned GroupW     = 16;
	localparam int unsigned AddrW      = GroupCount * GroupW;
	localparam int unsigned HalfW      = AddrW / 2;
	localparam int unsigned DigitMax   = 4;

	// Depth of the queue between front and back
	localparam int unsigned QueueDepth = 2;

	// Class of one character word
	typedef enum logic [1:0] {
		WK_HEX,
		WK_COLON,
		WK_BAD
	} word_kind_t;

	// Classified character word
	typedef struct packed {
		word_kind_t  kind;
		logic [3:0]  nibble;
		logic        last;
	} iptp_word_t;

endpackage

@@ rtl/core/iptp_if.sv @@
// Channel interfaces: character words in, address words out.
interface iptp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_char;
	logic       last_char;

	modport source(output valid, text_char, last_char, input ready);
	modport sink(input valid, text_char, last_char, output ready);
endinterface

interface iptp_res_if;
	logic        valid;
	logic        ready;
	logic [63:0] addr_high;
	logic [63:0] addr_low;
	logic        parse_ok;

	modport source(output valid, addr_high, addr_low, parse_ok, input ready);
	modport sink(input valid, addr_high, addr_low, parse_ok, output ready);
endinterface

@@ rtl/core/ipv6_text_address_parser.sv @@
// Top level of the IPv6 text address parser: classifying front, word queue, parsing back.
// A final character passes through the front stage register, the word queue and the result register.
// Throughput: one character per cycle; a result register and a queue decouple
// the character side from the result side, limited only by result back-pressure.
// Gap expansion is a combinational group shifter in the back stage.
// Reset (arst_n low) clears all control and parse state at once; no clearing pass.
module ipv6_text_address_parser import iptp_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	iptp_char_if.sink  chars,
	iptp_res_if.source result
);

	logic       q_push;
	logic       q_full;
	logic       q_pop;
	logic       q_empty;
	iptp_word_t q_in_word;
	iptp_word_t q_out_word;

	// Classifying front
	iptp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.q_full (q_full),
		.q_push (q_push),
		.q_word (q_in_word)
	);

	// Word queue
	iptp_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (q_in_word),
		.full      (q_full),
		.pop       (q_pop),
		.pop_word  (q_out_word),
		.empty     (q_empty)
	);

	// Parsing back
	iptp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.word    (q_out_word),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.result  (result)
	);

endmodule

@@ rtl/core/iptp_front.sv @@
// Front stage: accepts characters, classifies them and pushes them to the queue.
module iptp_front import iptp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	iptp_char_if.sink  chars,
	input  logic       q_full,
	output logic       q_push,
	output iptp_word_t q_word
);

	// Character to word class and nibble value
	function automatic iptp_word_t classify(input logic [7:0] c, input logic last);
		iptp_word_t w;
		w.kind   = WK_BAD;
		w.nibble = '0;
		w.last   = last;
		if (c == CharColon) begin
			w.kind = WK_COLON;
		end else if (c >= CharDigit0 && c <= CharDigit9) begin
			w.kind   = WK_HEX;
			w.nibble = 4'(c - CharDigit0);
		end else if (c >= CharLowerA && c <= CharLowerF) begin
			w.kind   = WK_HEX;
			w.nibble = 4'(c - CharLowerA + HexTen);
		end else if (c >= CharUpperA && c <= CharUpperF) begin
			w.kind   = WK_HEX;
			w.nibble = 4'(c - CharUpperA + HexTen);
		end
		return w;
	endfunction

	logic       valid_s1;
	iptp_word_t word_s1;

	// Stage register frees up whenever its word moves into the queue
	assign chars.ready = !valid_s1 || !q_full;
	assign q_push      = valid_s1 && !q_full;
	assign q_word      = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			word_s1 <= classify(chars.text_char, chars.last_char);
		end
	end

endmodule

@@ rtl/core/iptp_fifo.sv @@
// Short word queue between the classifying front and the parsing back.
module iptp_fifo import iptp_pkg::*; #(
	parameter int unsigned DEPTH = QueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  iptp_word_t push_word,
	output logic       full,
	input  logic       pop,
	output iptp_word_t pop_word,
	output logic       empty
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	iptp_word_t      mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full     = (count_q == FullCnt);
	assign empty    = (count_q == '0);
	assign pop_word = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/core/iptp_back.sv @@
// Back stage: group/gap parsing, gap expansion and the result register.
module iptp_back import iptp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  iptp_word_t word,
	input  logic       q_empty,
	output logic       q_pop,
	iptp_res_if.source result
);

	localparam logic [3:0] GroupMax = 4'(GroupCount);
	localparam logic [2:0] DigitLim = 3'(DigitMax);

	// Parse state
	logic [3:0]        gc_q;
	logic [3:0]        gp_q;
	logic              gap_q;
	logic              prev_q;
	logic [GroupW-1:0] gval_q;
	logic [2:0]        gdig_q;
	logic              err_q;
	logic [GroupW-1:0] grp_q [GroupCount];

	// Result register
	logic              out_valid_q;
	logic [HalfW-1:0]  high_q;
	logic [HalfW-1:0]  low_q;
	logic              ok_q;

	// Next parse state
	logic [3:0]        n_gc;
	logic [3:0]        n_gp;
	logic              n_gap;
	logic              n_prev;
	logic [GroupW-1:0] n_gval;
	logic [2:0]        n_gdig;
	logic              n_err;
	logic              wr_en;
	logic [2:0]        wr_idx;
	logic [GroupW-1:0] wr_val;

	logic [AddrW-1:0]  full_vec;
	logic [AddrW-1:0]  shift_vec;
	logic [AddrW-1:0]  fin_vec;
	logic [3:0]        shift_n;
	logic [3:0]        thr;
	logic              out_free;
	logic              out_take;

	// Handshake: non-final words always drain, the final one needs a free result slot
	assign out_free = !out_valid_q || result.ready;
	assign q_pop    = !q_empty && (!word.last || out_free);
	assign out_take = q_pop && word.last;

	assign result.valid     = out_valid_q;
	assign result.addr_high = high_q;
	assign result.addr_low  = low_q;
	assign result.parse_ok  = ok_q;

	// Per-character parse step, then the closing of an open group on the last word
	always_comb begin
		n_gc   = gc_q;
		n_gp   = gp_q;
		n_gap  = gap_q;
		n_prev = prev_q;
		n_gval = gval_q;
		n_gdig = gdig_q;
		n_err  = err_q;
		wr_en  = 1'b0;
		wr_idx = gc_q[2:0];
		wr_val = gval_q;
		if (!err_q) begin
			unique case (word.kind)
				WK_COLON: begin
					if (gdig_q != '0) begin
						if (gc_q >= GroupMax) begin
							n_err = 1'b1;
						end else begin
							wr_en = 1'b1;
							n_gc  = gc_q + 1'b1;
						end
						n_gval = '0;
						n_gdig = '0;
					end
					if (prev_q) begin
						if (gap_q) begin
							n_err = 1'b1;
						end else begin
							n_gap = 1'b1;
							n_gp  = n_gc;
						end
					end
					n_prev = 1'b1;
				end
				WK_HEX: begin
					if (gdig_q >= DigitLim) begin
						n_err = 1'b1;
					end else begin
						n_gval = {gval_q[GroupW-5:0], word.nibble};
						n_gdig = gdig_q + 1'b1;
						n_prev = 1'b0;
					end
				end
				default: begin
					n_err = 1'b1;
				end
			endcase
		end
		if (word.last && !n_err && n_gdig != '0) begin
			if (n_gc >= GroupMax) begin
				n_err = 1'b1;
			end else begin
				wr_en  = 1'b1;
				wr_idx = n_gc[2:0];
				wr_val = n_gval;
				n_gc   = n_gc + 1'b1;
			end
		end
	end

	// Gap expansion: groups after the gap move to the end of the address
	always_comb begin
		for (int k = 0; k < GroupCount; k++) begin
			if (4'(k) < n_gc) begin
				full_vec[AddrW-1-GroupW*k -: GroupW] =
					(wr_en && wr_idx == 3'(k)) ? wr_val : grp_q[k];
			end else begin
				full_vec[AddrW-1-GroupW*k -: GroupW] = '0;
			end
		end
		shift_n   = GroupMax - n_gc;
		shift_vec = full_vec >> {shift_n, 4'b0000};
		thr       = shift_n + n_gp;
		for (int k = 0; k < GroupCount; k++) begin
			if (!n_gap || 4'(k) < n_gp) begin
				fin_vec[AddrW-1-GroupW*k -: GroupW] = full_vec[AddrW-1-GroupW*k -: GroupW];
			end else if (4'(k) >= thr) begin
				fin_vec[AddrW-1-GroupW*k -: GroupW] = shift_vec[AddrW-1-GroupW*k -: GroupW];
			end else begin
				fin_vec[AddrW-1-GroupW*k -: GroupW] = '0;
			end
		end
	end

	// Parse state; the final word clears it for the next address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gc_q   <= '0;
			gp_q   <= '0;
			gap_q  <= 1'b0;
			prev_q <= 1'b0;
			gval_q <= '0;
			gdig_q <= '0;
			err_q  <= 1'b0;
		end else if (q_pop) begin
			if (word.last) begin
				gc_q   <= '0;
				gp_q   <= '0;
				gap_q  <= 1'b0;
				prev_q <= 1'b0;
				gval_q <= '0;
				gdig_q <= '0;
				err_q  <= 1'b0;
			end else begin
				gc_q   <= n_gc;
				gp_q   <= n_gp;
				gap_q  <= n_gap;
				prev_q <= n_prev;
				gval_q <= n_gval;
				gdig_q <= n_gdig;
				err_q  <= n_err;
			end
		end
	end

	// Group store; entries at or above the group count read as zero
	always_ff @(posedge clk) begin
		if (q_pop && wr_en) begin
			grp_q[wr_idx] <= wr_val;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_take) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; an error gives an all-zero address
	always_ff @(posedge clk) begin
		if (out_take) begin
			high_q <= n_err ? '0 : fin_vec[AddrW-1:HalfW];
			low_q  <= n_err ? '0 : fin_vec[HalfW-1:0];
			ok_q   <= !n_err;
		end
	end

endmodule

@@ rtl/core/iptp_checker.sv @@
// Port-level checks of the IPv6 text address parser, bound to its top level.
module iptp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] out_high,
	input logic [63:0] out_low,
	input logic        out_ok
);

	logic [7:0] pend_q;
	logic       last_acc;
	logic       out_acc;

	assign last_acc = in_valid && in_ready && in_last;
	assign out_acc  = out_valid && out_ready;

	// Final characters taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({last_acc, out_acc})
				2'b10:   pend_q <= pend_q + 1'b1;
				2'b01:   pend_q <= pend_q - 1'b1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	// A stalled word stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// A stalled word keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_high) && $stable(out_low) && $stable(out_ok))
		else $error("result word changed while stalled");

	// A failed parse reports an all-zero address
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ok |-> out_high == 64'd0 && out_low == 64'd0)
		else $error("nonzero address on failed parse");

	// Every result answers an earlier final character
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 8'd0)
		else $error("result word without a final character");

endmodule

bind ipv6_text_address_parser iptp_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (chars.valid),
	.in_ready  (chars.ready),
	.in_last   (chars.last_char),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_high  (result.addr_high),
	.out_low   (result.addr_low),
	.out_ok    (result.parse_ok)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the IPv6 text address parser.
`timescale 1ns / 100ps

module testbench;
	import iptp_pkg::*;

	// One character word on its way to the parser
	typedef struct {
		logic [7:0] ch;
		logic       last;
	} char_word_t;

	// One expected address word
	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
		logic        ok;
	} addr_word_t;

	logic clk = 1'b0;
	logic arst_n;

	iptp_char_if chars_if();
	iptp_res_if  result_if();

	ipv6_text_address_parser i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.result (result_if)
	);

	always #5 clk = ~clk;

	char_word_t pending_chars[$];
	addr_word_t expected_addrs[$];
	int         total_chars;
	int         accepted_chars;
	int         fault_count;

	// Parser shadow state
	logic [7:0]  shadow_bytes[16];
	logic [3:0]  shadow_groups;
	logic [3:0]  shadow_gap_at;
	logic        shadow_gap_seen;
	logic        shadow_prev_colon;
	logic [15:0] shadow_group_val;
	logic [2:0]  shadow_digits;
	logic        shadow_error;

	function automatic void clear_shadow();
		for (int i = 0; i < 16; i++)
			shadow_bytes[i] = 8'h00;
		shadow_groups     = '0;
		shadow_gap_at     = '0;
		shadow_gap_seen   = 1'b0;
		shadow_prev_colon = 1'b0;
		shadow_group_val  = '0;
		shadow_digits     = '0;
		shadow_error      = 1'b0;
	endfunction

	// Sort a character into hex digit, colon or anything else
	function automatic word_kind_t classify_char(input logic [7:0] c, output logic [3:0] nib);
		nib = 4'h0;
		if (c == CharColon)
			return WK_COLON;
		if (c >= CharDigit0 && c <= CharDigit9) begin
			nib = 4'(c - CharDigit0);
			return WK_HEX;
		end
		if (c >= CharLowerA && c <= CharLowerF) begin
			nib = 4'(c - CharLowerA + HexTen);
			return WK_HEX;
		end
		if (c >= CharUpperA && c <= CharUpperF) begin
			nib = 4'(c - CharUpperA + HexTen);
			return WK_HEX;
		end
		return WK_BAD;
	endfunction

	// Store the open group, or flag a ninth group
	function automatic void close_open_group();
		int slot;
		if (shadow_digits == 0)
			return;
		if (shadow_groups >= 8) begin
			shadow_error = 1'b1;
		end else begin
			slot = 2 * int'(shadow_groups);
			shadow_bytes[slot & 15]       = shadow_group_val[15:8];
			shadow_bytes[(slot + 1) & 15] = shadow_group_val[7:0];
			shadow_groups = shadow_groups + 4'd1;
		end
		shadow_group_val = '0;
		shadow_digits    = '0;
	endfunction

	function automatic void take_char(input logic [7:0] c);
		logic [3:0] nib;
		word_kind_t kind;
		if (shadow_error)
			return;
		kind = classify_char(c, nib);
		case (kind)
			WK_COLON: begin
				close_open_group();
				if (shadow_prev_colon) begin
					if (shadow_gap_seen) begin
						shadow_error = 1'b1;
					end else begin
						shadow_gap_seen = 1'b1;
						shadow_gap_at   = shadow_groups;
					end
				end
				shadow_prev_colon = 1'b1;
			end
			WK_HEX: begin
				if (shadow_digits >= DigitMax) begin
					shadow_error = 1'b1;
				end else begin
					shadow_group_val  = {shadow_group_val[11:0], nib};
					shadow_digits     = shadow_digits + 3'd1;
					shadow_prev_colon = 1'b0;
				end
			end
			default: shadow_error = 1'b1;
		endcase
	endfunction

	// Expand the gap and queue the address this text should give
	function automatic void finish_address();
		logic [7:0] fin[16];
		addr_word_t w;
		int span;
		int tail;
		int gc;
		if (!shadow_error)
			close_open_group();
		fin = shadow_bytes;
		if (!shadow_error && shadow_gap_seen) begin
			gc   = int'(shadow_groups);
			span = 16 - 2 * int'(shadow_gap_at);
			tail = 2 * (gc - int'(shadow_gap_at));
			for (int i = 0; i < span; i++)
				fin[15 - i] = (i < tail) ? shadow_bytes[(2 * gc - 1 - i) & 15] : 8'h00;
		end
		w.hi = '0;
		w.lo = '0;
		if (!shadow_error) begin
			for (int i = 0; i < 8; i++) begin
				w.hi = {w.hi[55:0], fin[i]};
				w.lo = {w.lo[55:0], fin[8 + i]};
			end
		end
		w.ok = !shadow_error;
		expected_addrs.push_back(w);
		clear_shadow();
	endfunction

	function automatic void queue_char(input logic [7:0] c, input logic last);
		char_word_t w;
		w.ch   = c;
		w.last = last;
		pending_chars.push_back(w);
		total_chars++;
	endfunction

	function automatic void queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			queue_char(s[i], i == s.len() - 1);
	endfunction

	function automatic logic [7:0] random_hex_char();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10)
			return CharDigit0 + 8'(v);
		if ($urandom_range(0, 1))
			return CharUpperA + 8'(v - 10);
		return CharLowerA + 8'(v - 10);
	endfunction

	// Mostly well-formed address text, now and then broken or noisy
	function automatic void queue_random_address();
		logic [7:0] txt[$];
		int n_grp;
		int gap_at;
		int nd;
		bit use_gap;
		n_grp = $urandom_range(0, 8);
		if ($urandom_range(0, 11) == 0)
			n_grp = $urandom_range(9, 10);
		use_gap = $urandom_range(0, 2) != 0;
		gap_at  = $urandom_range(0, n_grp);
		if ($urandom_range(0, 9) == 0)
			txt.push_back(CharColon);
		for (int g = 0; g < n_grp; g++) begin
			if (use_gap && g == gap_at) begin
				txt.push_back(CharColon);
				txt.push_back(CharColon);
			end else if (g > 0) begin
				txt.push_back(CharColon);
			end
			nd = ($urandom_range(0, 19) == 0) ? 5 : $urandom_range(1, 4);
			for (int d = 0; d < nd; d++)
				txt.push_back(random_hex_char());
			// occasional second gap
			if ($urandom_range(0, 24) == 0) begin
				txt.push_back(CharColon);
				txt.push_back(CharColon);
			end
		end
		if (use_gap && gap_at == n_grp) begin
			txt.push_back(CharColon);
			txt.push_back(CharColon);
		end
		if ($urandom_range(0, 9) == 0)
			txt.push_back(CharColon);
		if (txt.size() > 0 && $urandom_range(0, 9) == 0)
			txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 19) == 0)
			txt.insert($urandom_range(0, txt.size()), 8'($urandom_range(0, 255)));
		if (txt.size() == 0)
			txt.push_back(8'($urandom_range(0, 255)));
		for (int i = 0; i < txt.size(); i++)
			queue_char(txt[i], i == txt.size() - 1);
	endfunction

	// Idling is off near the end of the run
	logic calm_tail;
	assign calm_tail = pending_chars.size() < 200;

	// Character driver
	char_word_t next_char;
	int         char_gap;
	bit         src_idle_on = 1'b1;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_if.valid     <= 1'b0;
			chars_if.text_char <= 8'h00;
			chars_if.last_char <= 1'b0;
			char_gap = 0;
			clear_shadow();
		end else begin
			if (chars_if.valid && chars_if.ready) begin
				accepted_chars++;
				take_char(chars_if.text_char);
				if (chars_if.last_char)
					finish_address();
			end
			if ($urandom_range(0, 99) == 0)
				src_idle_on = !src_idle_on;
			if (!chars_if.valid || chars_if.ready) begin
				if (char_gap > 0) begin
					chars_if.valid <= 1'b0;
					char_gap--;
				end else if (pending_chars.size() > 0) begin
					if (src_idle_on && !calm_tail && $urandom_range(0, 5) == 0) begin
						chars_if.valid <= 1'b0;
						char_gap = $urandom_range(1, 19) - 1;
					end else begin
						next_char = pending_chars.pop_front();
						chars_if.valid     <= 1'b1;
						chars_if.text_char <= next_char.ch;
						chars_if.last_char <= next_char.last;
					end
				end else begin
					chars_if.valid <= 1'b0;
				end
			end
		end
	end

	// Address monitor and back-pressure
	addr_word_t want;
	int         result_stall;
	bit         sink_idle_on = 1'b1;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			result_stall = 0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				if (expected_addrs.size() == 0) begin
					$display("%0t: unexpected address word hi=%h lo=%h ok=%b", $time,
						result_if.addr_high, result_if.addr_low, result_if.parse_ok);
					fault_count++;
				end else begin
					want = expected_addrs.pop_front();
					if (result_if.addr_high !== want.hi) begin
						$display("%0t: addr_high expected %h, actual %h", $time,
							want.hi, result_if.addr_high);
						fault_count++;
					end
					if (result_if.addr_low !== want.lo) begin
						$display("%0t: addr_low expected %h, actual %h", $time,
							want.lo, result_if.addr_low);
						fault_count++;
					end
					if (result_if.parse_ok !== want.ok) begin
						$display("%0t: parse_ok expected %b, actual %b", $time,
							want.ok, result_if.parse_ok);
						fault_count++;
					end
				end
			end
			if ($urandom_range(0, 99) == 0)
				sink_idle_on = !sink_idle_on;
			if (result_stall > 0) begin
				result_if.ready <= 1'b0;
				result_stall--;
			end else if (sink_idle_on && !calm_tail && $urandom_range(0, 5) == 0) begin
				result_if.ready <= 1'b0;
				result_stall = $urandom_range(1, 19) - 1;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		arst_n             = 1'b0;
		chars_if.valid     = 1'b0;
		chars_if.text_char = 8'h00;
		chars_if.last_char = 1'b0;
		result_if.ready    = 1'b0;

		// directed: gap alone, loose syntax, bad characters, long group, second gap
		queue_text("::");
		queue_text("Ff:09:");
		queue_char(8'hFF, 1'b1);
		queue_char(8'h00, 1'b0);
		queue_char(CharDigit0 + 8'd1, 1'b1);
		queue_text("12345");
		queue_text("::1::");
		while (total_chars < 1470)
			queue_random_address();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_chars < total_chars)
			@(posedge clk);
		while (expected_addrs.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fault_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
